FILE: rtl/core/swm_pkg.sv
// ---------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window median core
// Sizes of the cell row, sample keys, ages and the cell control and link
// structures.
// ---------------------------------------------------------------------------
package swm_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 7;
  localparam int AGE_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

  // sign bit flipped so that unsigned order equals signed order
  localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic [DATA_W-1:0] key_t;
  typedef logic [AGE_W-1:0]  age_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CFG_W-1:0]  cfg_t;

  typedef struct packed {
    logic vld;
    logic surv;
    logic gt;
    logic bef;
    key_t key;
    age_t age;
  } cell_link_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic full;
    key_t key;
    age_t last_age;
  } cell_ctl_t;

endpackage

FILE: rtl/core/swm_cell.sv
// ---------------------------------------------------------------------------
// swm_cell: one slot of the sorted window
// Holds one key with its age, compares it to the incoming key and takes its
// new content from itself, a neighbour or the incoming key.
// ---------------------------------------------------------------------------
module swm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  swm_pkg::cell_ctl_t ctl,
  input  swm_pkg::cell_link_t prv,
  input  swm_pkg::cell_link_t nxt,
  input  logic               bef_in,
  output logic               bef_out,
  output swm_pkg::cell_link_t lnk
);
  import swm_pkg::*;

  logic vld_r, vld_nxt;
  key_t key_r, key_nxt;
  age_t age_r, age_nxt;
  logic ev, surv, gt;
  logic own_keep, from_next, from_prev;

  assign ev      = ctl.full & vld_r & (age_r == ctl.last_age);
  assign surv    = vld_r & ~ev;
  assign gt      = key_r > ctl.key;
  assign bef_out = bef_in | ev;

  assign own_keep  = surv & (bef_in == gt);
  assign from_next = nxt.surv & nxt.bef & ~nxt.gt;
  assign from_prev = prv.surv & prv.gt & ~prv.bef;

  always_comb begin
    if (own_keep) begin
      key_nxt = key_r;
      age_nxt = age_r + age_t'(1);
    end else if (from_next) begin
      key_nxt = nxt.key;
      age_nxt = nxt.age + age_t'(1);
    end else if (from_prev) begin
      key_nxt = prv.key;
      age_nxt = prv.age + age_t'(1);
    end else begin
      key_nxt = ctl.key;
      age_nxt = '0;
    end
  end

  always_comb begin
    if (ctl.clr) begin
      vld_nxt = 1'b0;
    end else if (ctl.load && !ctl.full) begin
      vld_nxt = vld_r | prv.vld;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r <= key_nxt;
      age_r <= age_nxt;
    end
  end

  assign lnk = '{vld: vld_r, surv: surv, gt: gt, bef: bef_in, key: key_r, age: age_r};

endmodule

FILE: rtl/core/sliding_window_median_core.sv
// ---------------------------------------------------------------------------
// sliding_window_median_core: streaming lower median over a sliding window
// Row of sorting cells with per-entry ages, window size register and an
// output register for the median.
// ---------------------------------------------------------------------------
// Each transaction updates the whole cell row in the cycle it is accepted:
// once the window is full the oldest entry (found by its age) drops out, and
// the new sample slots in at its sorted place. Once the window has filled,
// every sample yields one median, read from the middle cell into the output
// register when that register is free; with the output ready the core takes
// one sample per clock, the median passing through the cell row and then the
// output register. No result is given until window_size samples have arrived.
// Writing the window size empties the window. A size of zero acts as one,
// sizes above 64 act as 64; for even sizes the lower middle value is returned.
// ---------------------------------------------------------------------------
module sliding_window_median_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [6:0]           cfg_data,     // window_size
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,     // [31:0] sample
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata     // [31:0] median
);
  import swm_pkg::*;

  cnt_t k_r, k_nxt;
  age_t last_age_r, kmid_r;
  cnt_t count_r, count_nxt;
  logic pend_r, pend_nxt;
  logic out_tvalid_r, out_tvalid_nxt;
  key_t out_key_r;
  logic cfg_acc, in_acc, out_load, full;
  key_t med_key;
  cell_ctl_t ctl;
  cell_link_t lnk [MAX_WINDOW];
  logic [MAX_WINDOW:0] bef;
  logic [MAX_WINDOW-1:0] vld_vec;

  localparam cell_link_t HEAD_LINK = '{vld: 1'b1, surv: 1'b0, gt: 1'b0, bef: 1'b0,
                                       key: '0, age: '0};
  localparam cell_link_t TAIL_LINK = '{vld: 1'b0, surv: 1'b0, gt: 1'b0, bef: 1'b0,
                                       key: '0, age: '0};

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;

  assign out_load  = pend_r & (~out_tvalid_r | out_tready);
  assign in_tready = ~pend_r | ~out_tvalid_r | out_tready;
  assign in_acc    = in_tvalid & in_tready;
  assign full      = (count_r == k_r);

  always_comb begin
    if (cfg_data == '0) begin
      k_nxt = cnt_t'(1);
    end else if (int'(cfg_data) > MAX_WINDOW) begin
      k_nxt = cnt_t'(MAX_WINDOW);
    end else begin
      k_nxt = cnt_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r        <= cnt_t'(1);
      last_age_r <= '0;
      kmid_r     <= '0;
    end else if (cfg_acc) begin
      k_r        <= k_nxt;
      last_age_r <= age_t'(k_nxt - cnt_t'(1));
      kmid_r     <= age_t'((k_nxt - cnt_t'(1)) >> 1);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cfg_acc) begin
      count_nxt = '0;
    end else if (in_acc && !full) begin
      count_nxt = count_r + cnt_t'(1);
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (cfg_acc) begin
      pend_nxt = 1'b0;
    end else if (in_acc && (full || (count_r + cnt_t'(1) == k_r))) begin
      pend_nxt = 1'b1;
    end else if (out_load) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_key_r <= med_key;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_key_r ^ SIGN_FLIP;

  assign ctl = '{load: in_acc, clr: cfg_acc, full: full,
                 key: key_t'(in_tdata) ^ SIGN_FLIP, last_age: last_age_r};

  assign bef[0] = 1'b0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    cell_link_t prv_lnk, nxt_lnk;
    if (i == 0) begin : g_head
      assign prv_lnk = HEAD_LINK;
    end else begin : g_mid_prv
      assign prv_lnk = lnk[i-1];
    end
    if (i == MAX_WINDOW - 1) begin : g_tail
      assign nxt_lnk = TAIL_LINK;
    end else begin : g_mid_nxt
      assign nxt_lnk = lnk[i+1];
    end
    swm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .prv     (prv_lnk),
      .nxt     (nxt_lnk),
      .bef_in  (bef[i]),
      .bef_out (bef[i+1]),
      .lnk     (lnk[i])
    );
    assign vld_vec[i] = lnk[i].vld;
  end

  always_comb begin
    med_key = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      med_key = med_key | (lnk[i].key & {DATA_W{age_t'(i) == kmid_r}});
    end
  end

`ifndef SYNTH
  a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= k_r)
    else $error("fill count beyond window size");

  a_cells_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) == int'(count_r))
    else $error("occupied cells differ from fill count");

  a_pend_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> full)
    else $error("median pending with window not full");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cfg_acc && !full) |=> (count_r == $past(count_r) + cnt_t'(1)))
    else $error("fill count did not advance");
`endif

endmodule

FILE: dv/sliding_window_median_checker.sv
// ---------------------------------------------------------------------------
// sliding_window_median_checker: median predictor and result scoreboard
// Watches the window size, sample and median channels of the core. Each
// window size write empties its own copy of the window; each accepted sample
// goes through a delay line and an ascending store, and once the window is
// full the lower median is queued. Every accepted median is compared with the
// oldest queued one. Reports the mismatch count and the medians still due.
// ---------------------------------------------------------------------------
module sliding_window_median_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  swm_pkg::cfg_t              cfg_data,     // window_size
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [swm_pkg::DATA_W-1:0] in_tdata,     // [31:0] sample
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [swm_pkg::DATA_W-1:0] out_tdata,    // [31:0] median
  output int                         mismatches,
  output int                         medians_due
);
  import swm_pkg::*;

  cfg_t                     win_size  = cfg_t'(1);
  int                       fill_cnt  = 0;
  int                       oldest    = 0;
  int                       err_cnt   = 0;
  logic signed [DATA_W-1:0] delay_line [MAX_WINDOW];
  logic signed [DATA_W-1:0] ordered    [MAX_WINDOW];
  logic signed [DATA_W-1:0] median_q   [$];

  task automatic slide_window(input  logic signed [DATA_W-1:0] smp,
                              output bit                       got,
                              output logic signed [DATA_W-1:0] med);
    int k;
    int pos;
    int slot;
    k   = (win_size == 0) ? 1 : (win_size > MAX_WINDOW) ? MAX_WINDOW : int'(win_size);
    got = 1'b0;
    med = '0;
    if (fill_cnt < k) begin
      delay_line[fill_cnt] = smp;
      pos = fill_cnt;
      while (pos > 0 && ordered[pos-1] > smp) begin
        ordered[pos] = ordered[pos-1];
        pos--;
      end
      ordered[pos] = smp;
      fill_cnt++;
      oldest = 0;
      if (fill_cnt < k) return;
    end else begin
      slot = oldest % k;
      // drop one entry equal to the oldest sample
      pos = 0;
      while (pos < k && ordered[pos] != delay_line[slot]) pos++;
      for (; pos + 1 < k; pos++) ordered[pos] = ordered[pos+1];
      pos = k - 1;
      while (pos > 0 && ordered[pos-1] > smp) begin
        ordered[pos] = ordered[pos-1];
        pos--;
      end
      ordered[pos]     = smp;
      delay_line[slot] = smp;
      oldest           = (slot + 1) % k;
    end
    got = 1'b1;
    med = ordered[(k-1)/2];
  endtask

  always @(posedge clk) begin : watch
    logic signed [DATA_W-1:0] med;
    logic signed [DATA_W-1:0] want;
    bit                       got;
    if (!rst_n) begin
      win_size = cfg_t'(1);
      fill_cnt = 0;
      oldest   = 0;
      median_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        win_size = cfg_data;
        fill_cnt = 0;
        oldest   = 0;
      end
      if (out_tvalid && out_tready) begin
        if (median_q.size() == 0) begin
          $display("%0t: median with none due, expected none, got %0d",
                   $time, $signed(out_tdata));
          err_cnt++;
        end else begin
          want = median_q.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: median mismatch, expected %0d, got %0d",
                     $time, want, $signed(out_tdata));
            err_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        slide_window(in_tdata, got, med);
        if (got) median_q.push_back(med);
      end
    end
    mismatches  <= err_cnt;
    medians_due <= median_q.size();
  end

endmodule

FILE: dv/sliding_window_median_core_test.sv
// ---------------------------------------------------------------------------
// sliding_window_median_core_test: stimulus and verdict for the median core
// Directed samples at the value extremes, window sizes of zero, one, odd and
// even, repeated values and a refill after a size write, then random phases
// over many window sizes with random gaps and output stalls. Results are
// checked by the checker module placed beside the core.
// ---------------------------------------------------------------------------
module sliding_window_median_core_test;
  import swm_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 850;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  cfg_t              cfg_data;     // window_size
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;     // [31:0] sample
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;    // [31:0] median
  int                mismatches;
  int                medians_due;
  bit                quiet_phase = 1'b0;
  int                stall_left  = 0;
  logic [DATA_W-1:0] recent      = '0;

  sliding_window_median_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sliding_window_median_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .medians_due (medians_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output stalls, mostly short, some long
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (quiet_phase || $urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
    end
  end

  task automatic send_sample(input logic [DATA_W-1:0] smp);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    recent = smp;
    if (quiet_phase) gap = 0;
    else begin
      gap = $urandom_range(0, 99);
      gap = (gap < 60) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the input until every median is back and the core has settled
  task automatic idle_wait();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (medians_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input cfg_t size);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    cfg_t              corner_sizes [6];
    cfg_t              size;
    logic [DATA_W-1:0] smp;
    int                sent;
    int                phase;
    int                k;
    int                n;
    int                drain_at;
    int                pick;
    corner_sizes = '{7'd64, 7'd127, 7'd65, 7'd2, 7'd0, 7'd1};
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // window of one after reset passes samples through
    send_sample(32'h0000_0000);
    send_sample(32'h7fff_ffff);
    send_sample(32'h8000_0000);
    send_sample(32'hffff_ffff);
    send_sample(32'h0000_0001);
    // size zero acts as one
    idle_wait();
    write_window(7'd0);
    send_sample(32'h5a5a_5a5a);
    send_sample(32'ha5a5_a5a5);
    // odd window with repeated values
    idle_wait();
    write_window(7'd3);
    send_sample(32'd7);
    send_sample(32'd7);
    send_sample(-32'sd3);
    send_sample(32'd7);
    send_sample(32'h8000_0000);
    send_sample(32'h7fff_ffff);
    send_sample(32'd7);
    // size write in mid fill restarts filling, even window gives lower median
    idle_wait();
    write_window(7'd4);
    send_sample(32'd1);
    send_sample(32'd2);
    idle_wait();
    write_window(7'd4);
    send_sample(32'd10);
    send_sample(-32'sd10);
    send_sample(32'd20);
    send_sample(-32'sd20);
    send_sample(32'd5);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase < 6) size = corner_sizes[phase];
      else if ($urandom_range(0, 1) == 0) size = cfg_t'($urandom_range(1, 8));
      else size = cfg_t'($urandom_range(0, 127));
      k = (size == 0) ? 1 : (size > MAX_WINDOW) ? MAX_WINDOW : int'(size);
      n = k - 1 + $urandom_range(10, 50);
      drain_at = $urandom_range(0, n - 1);
      idle_wait();
      quiet_phase = ($urandom_range(0, 3) == 0);
      write_window(size);
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) smp = $urandom;
        else if (pick < 8) smp = $urandom_range(0, 8) - 4;
        else if (pick == 8) smp = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        else smp = recent;
        send_sample(smp);
        if (i == drain_at) idle_wait();
      end
      sent += n;
      phase++;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (medians_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && medians_due == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
